>>> hw/rtl/sac_pkg.sv
// shared constants and types for the set-associative cache tag store
// no dependencies; imported by set_assoc_cache_tag_store
`default_nettype none

package sac_pkg;

  // default geometry
  localparam int unsigned DEF_SETS       = 256;
  localparam int unsigned DEF_WAYS       = 4;
  localparam int unsigned DEF_ADDR_WIDTH = 32;

  // configuration port
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_INDEX_BITS = 3'd0,
    CFG_OFFSET_BITS    = 3'd1,
    CFG_ALLOC_MISS     = 3'd2,
    CFG_THRU_MODE      = 3'd3,
    CFG_LRU_MODE       = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_SET_INDEX_BITS = 4'd8;
  localparam logic [CFG_W-1:0] RST_OFFSET_BITS    = 4'd4;

  // address split
  localparam int unsigned IDX_RAW_W = 15;               // widest masked set index
  localparam int unsigned WORDS_W   = 14;               // (2^15)/4 words per block at most

  // cost accounting
  localparam int unsigned MEM_COST  = 100;
  localparam int unsigned BC_W      = 20;               // words * MEM_COST
  localparam int unsigned SUM_W     = 21;               // 1 + 2 blocks + one write
  localparam int unsigned CYCLE_W   = 18;
  localparam logic [CYCLE_W-1:0] CYCLES_MAX = 18'h3FFFF;

endpackage

`default_nettype wire

>>> hw/rtl/sac_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds one cache set per row in the tag store
`default_nettype none

module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/set_assoc_cache_tag_store.sv
// set-associative cache tag store: lookup, fill, eviction and cost per access
// depends on sac_pkg and sac_ram
//
//  channel   signals                                  direction  transfer
//  request   start, busy, req_type, address            in         start && !busy
//  result    done, hit, wrote_back, cycles_added       out        done, one cycle
//  config    cfg_we, cfg_index, cfg_data               in         cfg_we
//
// after reset a clearing pass writes every set row, with busy high.
// an access runs from accept to the edge that takes done through these steps: address
// split, a reciprocal multiply and one correcting subtract for the set index modulo
// SETS, one ram read, one way per cycle through the shared tag/age comparator, and
// one row write-back.
// busy drops in the cycle done is shown, so the next access may start then.
// results cannot be stalled; done is a single-cycle strobe.
`default_nettype none

module set_assoc_cache_tag_store #(
  parameter int unsigned SETS       = sac_pkg::DEF_SETS,
  parameter int unsigned WAYS       = sac_pkg::DEF_WAYS,
  parameter int unsigned ADDR_WIDTH = sac_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type,
  input  wire logic [ADDR_WIDTH-1:0]         address,
  output logic                               done,
  output logic                               hit,
  output logic                               wrote_back,
  output logic [sac_pkg::CYCLE_W-1:0]        cycles_added,
  input  wire logic                          cfg_we,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sac_pkg::CFG_W-1:0]     cfg_data
);

  import sac_pkg::*;

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W = WAY_W;
  localparam int unsigned ENT_W  = 2 + RANK_W + ADDR_WIDTH;
  localparam int unsigned ROW_W  = WAYS * ENT_W;

  // floor(2^IDX_RAW_W / SETS); the estimated quotient is low by at most one
  localparam int unsigned RECIP_W = IDX_RAW_W + 1;
  localparam int unsigned PROD_W  = IDX_RAW_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((32'd1 << IDX_RAW_W) / SETS);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_SPLIT = 8'b00000100,
    S_QUOT  = 8'b00001000,
    S_REM   = 8'b00010000,
    S_READ  = 8'b00100000,
    S_SCAN  = 8'b01000000,
    S_WRITE = 8'b10000000
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] set_index_bits;
  logic [CFG_W-1:0] offset_bits;
  logic             alloc_miss;
  logic             thru_mode;
  logic             lru_mode;

  // transaction registers
  logic                  req_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [IDX_RAW_W-1:0]  raw_q;
  logic [BC_W-1:0]       bc_q;
  logic [IDX_RAW_W-1:0]  quot_q;
  logic [SET_W-1:0]      rem_q;
  logic [SET_W-1:0]      clr_q;
  logic [WAY_W-1:0]      w_q;

  // scan results
  logic              hit_q;
  logic [WAY_W-1:0]  hit_way_q;
  logic              inv_q;
  logic [WAY_W-1:0]  inv_way_q;
  logic [RANK_W-1:0] min_rank_q;
  logic [WAY_W-1:0]  min_way_q;

  // ram
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  sac_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (state == S_READ),
    .raddr(rem_q),
    .rdata(ram_rdata)
  );

  // unpacked row
  logic [WAYS-1:0]       v;
  logic [WAYS-1:0]       d;
  logic [RANK_W-1:0]     rk [WAYS];
  logic [ADDR_WIDTH-1:0] tg [WAYS];

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      v[i]  = ram_rdata[i*ENT_W + ENT_W - 1];
      d[i]  = ram_rdata[i*ENT_W + ENT_W - 2];
      rk[i] = ram_rdata[i*ENT_W + ADDR_WIDTH +: RANK_W];
      tg[i] = ram_rdata[i*ENT_W +: ADDR_WIDTH];
    end
  end

  // address split
  logic [4:0]           shamt;
  logic [IDX_RAW_W-1:0] idx_mask;
  logic [WORDS_W-1:0]   words;

  assign shamt    = 5'(set_index_bits) + 5'(offset_bits);
  assign idx_mask = IDX_RAW_W'((16'd1 << set_index_bits) - 16'd1);
  assign words    = WORDS_W'((16'd1 << offset_bits) >> 2);

  // set index modulo SETS: reciprocal multiply, then one compare and subtract
  logic [PROD_W-1:0]    quot_prod;
  logic [IDX_RAW_W-1:0] rem_est;
  logic [IDX_RAW_W-1:0] rem_fix;

  assign quot_prod = PROD_W'(raw_q) * PROD_W'(RECIP);

  always_comb begin
    rem_est = raw_q - IDX_RAW_W'(32'(quot_q) * SETS);
    rem_fix = (rem_est >= IDX_RAW_W'(SETS)) ? rem_est - IDX_RAW_W'(SETS) : rem_est;
  end

  // shared comparator for the way scan
  logic              tag_eq;
  logic              rank_lt;
  assign tag_eq  = (tg[w_q] == tag_q);
  assign rank_lt = (rk[w_q] < min_rank_q);

  // row update and cost
  logic              do_fill;
  logic [WAY_W-1:0]  tgt;
  logic              wb;
  logic              refresh;
  logic              store_mem;
  logic [RANK_W-1:0] cnt;
  logic [WAYS-1:0]       n_v;
  logic [WAYS-1:0]       n_d;
  logic [RANK_W-1:0]     n_rk [WAYS];
  logic [ADDR_WIDTH-1:0] n_tg [WAYS];
  logic [ROW_W-1:0]  row_new;
  logic [SUM_W-1:0]  sum;
  logic [CYCLE_W-1:0] cycles_next;

  always_comb begin
    do_fill = !hit_q && (!req_q || alloc_miss);
    tgt     = hit_q ? hit_way_q : (inv_q ? inv_way_q : min_way_q);
    wb      = do_fill && !inv_q && d[tgt];
    refresh = hit_q ? lru_mode : do_fill;
    n_v     = v;
    n_d     = d;
    cnt     = '0;
    for (int i = 0; i < WAYS; i++) begin
      n_rk[i] = rk[i];
      n_tg[i] = tg[i];
    end
    if (refresh) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) != tgt && v[i]) begin
          if (v[tgt] && rk[i] > rk[tgt]) begin
            n_rk[i] = rk[i] - RANK_W'(1);
          end
          cnt = cnt + RANK_W'(1);
        end
      end
      n_rk[tgt] = cnt;
    end
    if (do_fill) begin
      n_v[tgt]  = 1'b1;
      n_tg[tgt] = tag_q;
      n_d[tgt]  = req_q && !thru_mode;
    end
    if (hit_q && req_q && !thru_mode) begin
      n_d[tgt] = 1'b1;
    end
    for (int i = 0; i < WAYS; i++) begin
      row_new[i*ENT_W +: ENT_W] = {n_v[i], n_d[i], n_rk[i], n_tg[i]};
    end

    // store data to memory: write-through hits and fills, and store misses left unallocated
    store_mem = req_q && ((hit_q || do_fill) ? thru_mode : 1'b1);
    sum = SUM_W'(1)
        + (do_fill   ? SUM_W'(bc_q) : '0)
        + (wb        ? SUM_W'(bc_q) : '0)
        + (store_mem ? SUM_W'(MEM_COST) : '0);
    cycles_next = (sum > SUM_W'(CYCLES_MAX)) ? CYCLES_MAX : sum[CYCLE_W-1:0];
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || ((state == S_WRITE) && (hit_q || do_fill));
    ram_waddr = (state == S_CLEAR) ? clr_q : rem_q;
    ram_wdata = (state == S_CLEAR) ? '0 : row_new;
  end

  assign busy = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= RST_SET_INDEX_BITS;
      offset_bits    <= RST_OFFSET_BITS;
      alloc_miss     <= 1'b1;
      thru_mode      <= 1'b0;
      lru_mode       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_INDEX_BITS: set_index_bits <= cfg_data;
        CFG_OFFSET_BITS:    offset_bits    <= cfg_data;
        CFG_ALLOC_MISS:     alloc_miss     <= cfg_data[0];
        CFG_THRU_MODE:      thru_mode      <= cfg_data[0];
        CFG_LRU_MODE:       lru_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_q <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == SET_W'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          state <= S_QUOT;
        end
        S_QUOT: begin
          state <= S_REM;
        end
        S_REM: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (w_q == WAY_W'(WAYS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q  <= req_type;
      addr_q <= address;
    end
    if (state == S_SPLIT) begin
      tag_q  <= addr_q >> shamt;
      raw_q  <= IDX_RAW_W'(addr_q >> offset_bits) & idx_mask;
      bc_q   <= BC_W'(words) * BC_W'(MEM_COST);
    end
    if (state == S_QUOT) begin
      quot_q <= quot_prod[IDX_RAW_W +: IDX_RAW_W];
    end
    if (state == S_REM) begin
      rem_q  <= rem_fix[SET_W-1:0];
    end
    if (state == S_READ) begin
      w_q   <= '0;
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end
    if (state == S_SCAN) begin
      w_q <= w_q + WAY_W'(1);
      if (v[w_q] && tag_eq && !hit_q) begin
        hit_q     <= 1'b1;
        hit_way_q <= w_q;
      end
      if (!v[w_q] && !inv_q) begin
        inv_q     <= 1'b1;
        inv_way_q <= w_q;
      end
      // first way with the lowest rank is the oldest
      if (w_q == '0 || rank_lt) begin
        min_rank_q <= rk[w_q];
        min_way_q  <= w_q;
      end
    end
    if (state == S_WRITE) begin
      hit          <= hit_q;
      wrote_back   <= wb;
      cycles_added <= cycles_next;
    end
  end

endmodule

`default_nettype wire
